@@ rtl/ule_pkg.sv @@
// ule_pkg: shared types and character constants for the uuencode line encoder
// no dependencies; imported by the front, queue, back and top modules of the block
`default_nettype none

package ule_pkg;

  localparam int CNT_W = 6;                 // byte count per line, up to 45

  localparam logic [6:0] CH_SPACE = 7'd32;  // offset added to every six-bit code
  localparam logic [6:0] CH_GRAVE = 7'd96;  // length char of an empty line
  localparam logic [6:0] CH_NL    = 7'd10;  // line terminator

  // one line job handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] count;  // bytes in the line, zero means empty line only
    logic             bank;   // line store bank holding the bytes
    logic             tail;   // append the final empty line after this one
  } cmd_t;

  // back tells front that a bank has been read out
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

@@ rtl/ule_ram.sv @@
// ule_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 90
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ule_front.sv @@
// ule_front: accepts bytes, writes them to the line store, issues line jobs
// depends on ule_pkg
`default_nettype none

module ule_front #(
  parameter int LINE_BYTES = 45,
  parameter int ADDR_W     = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  output logic                   push,
  output ule_pkg::cmd_t          push_cmd,
  input  wire logic              q_full,
  input  wire ule_pkg::rel_t     rel,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [7:0]             wr_data
);

  import ule_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             acc;
  logic [CNT_W-1:0] cnt_after;
  logic             line_full;

  assign in_tready = !q_full && !busy_r[bank_r];
  assign acc       = in_tvalid && in_tready;
  assign cnt_after = count_r + CNT_W'(in_tuser);
  assign line_full = in_tuser && (cnt_after == CNT_W'(LINE_BYTES));

  assign wr_en   = acc && in_tuser;
  assign wr_addr = ADDR_W'(count_r) + (bank_r ? ADDR_W'(LINE_BYTES) : '0);
  assign wr_data = in_tdata;

  always_comb begin
    count_nxt      = count_r;
    bank_nxt       = bank_r;
    busy_nxt       = busy_r;
    push           = 1'b0;
    push_cmd.count = cnt_after;
    push_cmd.bank  = bank_r;
    push_cmd.tail  = in_tlast;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (acc) begin
      if (line_full || in_tlast) begin
        push      = 1'b1;
        count_nxt = '0;
        if (cnt_after != '0) begin
          busy_nxt[bank_r] = 1'b1;
          bank_nxt         = !bank_r;
        end
      end else begin
        count_nxt = cnt_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ule_cmd_fifo.sv @@
// ule_cmd_fifo: two-entry queue of line jobs between front and back
// depends on ule_pkg
`default_nettype none

module ule_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ule_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output ule_pkg::cmd_t      pop_cmd,
  output logic               full,
  output logic               empty
);

  import ule_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/ule_back.sv @@
// ule_back: reads a line from the store and emits its characters one per transfer
// depends on ule_pkg
`default_nettype none

module ule_back #(
  parameter int LINE_BYTES = 45,
  parameter int ADDR_W     = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire ule_pkg::cmd_t pop_cmd,
  output logic               pop,
  output ule_pkg::rel_t      rel,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  wire logic [7:0]    rd_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [6:0]         out_char,
  output logic               out_last
);

  import ule_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_LEN, B_FETCH, B_CHARS, B_NL, B_ELEN, B_ENL
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bank_r, bank_nxt;
  logic             tail_r, tail_nxt;
  logic [CNT_W-1:0] gpos_r, gpos_nxt;
  logic [1:0]       fk_r, fk_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [23:0]      word_r, word_nxt;
  logic             pend_r;
  logic             vld_r, vld_nxt;
  logic [6:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic             ld;
  logic [CNT_W-1:0] pos;
  logic [CNT_W:0]   gend;

  assign out_tvalid = vld_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

  assign ld      = !vld_r || out_tready;
  assign pos     = gpos_r + CNT_W'(fk_r);
  assign gend    = {1'b0, gpos_r} + (CNT_W+1)'(3);
  assign rd_en   = (state_r == B_FETCH) && (fk_r != 2'd3) && (pos < cnt_r);
  assign rd_addr = ADDR_W'(pos) + (bank_r ? ADDR_W'(LINE_BYTES) : '0);
  assign pop     = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bank_nxt  = bank_r;
    tail_nxt  = tail_r;
    gpos_nxt  = gpos_r;
    fk_nxt    = fk_r;
    ch_nxt    = ch_r;
    word_nxt  = word_r;
    vld_nxt   = vld_r && !out_tready;
    char_nxt  = char_r;
    last_nxt  = last_r;
    rel.valid = 1'b0;
    rel.bank  = bank_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          cnt_nxt   = pop_cmd.count;
          bank_nxt  = pop_cmd.bank;
          tail_nxt  = pop_cmd.tail;
          state_nxt = (pop_cmd.count != '0) ? B_LEN : B_ELEN;
        end
      end
      B_LEN: begin
        if (ld) begin
          vld_nxt   = 1'b1;
          char_nxt  = 7'(cnt_r) + CH_SPACE;
          last_nxt  = 1'b0;
          gpos_nxt  = '0;
          fk_nxt    = '0;
          state_nxt = B_FETCH;
        end
      end
      B_FETCH: begin
        // read issued at fk, data captured in the next cycle
        if (fk_r != 2'd0) begin
          word_nxt = {word_r[15:0], pend_r ? rd_data : 8'd0};
        end
        fk_nxt = fk_r + 2'd1;
        if (fk_r == 2'd3) begin
          ch_nxt    = '0;
          state_nxt = B_CHARS;
        end
      end
      B_CHARS: begin
        if (ld) begin
          vld_nxt  = 1'b1;
          char_nxt = {1'b0, word_r[23:18]} + CH_SPACE;
          last_nxt = 1'b0;
          word_nxt = {word_r[17:0], 6'd0};
          ch_nxt   = ch_r + 2'd1;
          if (ch_r == 2'd3) begin
            gpos_nxt = gend[CNT_W-1:0];
            fk_nxt   = '0;
            state_nxt = (gend >= {1'b0, cnt_r}) ? B_NL : B_FETCH;
          end
        end
      end
      B_NL: begin
        if (ld) begin
          vld_nxt   = 1'b1;
          char_nxt  = CH_NL;
          last_nxt  = !tail_r;
          rel.valid = 1'b1;
          state_nxt = tail_r ? B_ELEN : B_IDLE;
        end
      end
      B_ELEN: begin
        if (ld) begin
          vld_nxt   = 1'b1;
          char_nxt  = CH_GRAVE;
          last_nxt  = 1'b0;
          state_nxt = B_ENL;
        end
      end
      B_ENL: begin
        if (ld) begin
          vld_nxt   = 1'b1;
          char_nxt  = CH_NL;
          last_nxt  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      vld_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      pend_r  <= rd_en;
    end
    cnt_r  <= cnt_nxt;
    bank_r <= bank_nxt;
    tail_r <= tail_nxt;
    gpos_r <= gpos_nxt;
    fk_r   <= fk_nxt;
    ch_r   <= ch_nxt;
    word_r <= word_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/uuencode_line_encoder.sv @@
// uuencode_line_encoder: top level, byte stream in, uuencoded line characters out
// depends on ule_pkg, ule_front, ule_cmd_fifo, ule_back, ule_ram
//
//   channel  | direction | tdata                  | tuser        | tlast
//   ---------+-----------+------------------------+--------------+--------------
//   in_      | slave     | [7:0] data_byte        | byte_present | end_of_stream
//   out_     | master    | [6:0] out_char, [7] 0  | -            | last_of_run
//
// the front stalls only while the bank it is filling still waits to be read out
// or the two-entry job queue is full
// a line's back sequence: taking the job, the length char, then per three-byte
// group up to three store reads and four char transfers, then the newline; the
// final empty line adds a grave length char and its newline
// the line store is two banks of LINE_BYTES bytes in one ram, so one line is
// filled while the previous one is sent out
// rst_n is synchronous, active low; it clears the job queue, the front counter,
// bank busy flags, back state and output valid; the line store itself is not cleared
// out_tvalid only drops after a transfer; while a char is pending and out_tready
// is low, the back stage waits in its char states
`default_nettype none

module uuencode_line_encoder #(
  parameter int LINE_BYTES = 45
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] byte_present
  input  wire logic       in_tlast,   // end_of_stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] out_char, [7] zero fill
  output logic            out_tlast   // last_of_run
);

  import ule_pkg::*;

  // two banks of the line store
  localparam int RAM_DEPTH = 2 * LINE_BYTES;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic pop;
  cmd_t pop_cmd;
  logic q_empty;

  // bank release from back to front
  rel_t rel;

  // store ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic [6:0] out_char;

  ule_front #(
    .LINE_BYTES(LINE_BYTES),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .rel      (rel),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  ule_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  ule_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ule_back #(
    .LINE_BYTES(LINE_BYTES),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .rel       (rel),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  // char in the low seven bits, zero fill to a whole byte
  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

@@ rtl/ule_checker.sv @@
// ule_checker: port-level assertions for the uuencode line encoder
// depends on uuencode_line_encoder ports only; bound to the top level below
`default_nettype none

module ule_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tuser,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out stalled transfer changed");

  // every run ends on a newline
  a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 8'd10)
    else $error("run does not end on newline");

  // chars other than newline are printable
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata != 8'd10 |-> out_tdata >= 8'd32 && out_tdata <= 8'd96)
    else $error("char out of range");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind uuencode_line_encoder ule_checker u_ule_checker (.*);

`default_nettype wire
